FILE: rtl/dcc_pkg.sv
package dcc_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned TapsW = 3;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [TapsW-1:0] TapsReset = 3'd4;

  // register index, taken from paddr[2]
  localparam logic RegTapsInUse = 1'b0;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_WEIGHT  = 2'd1,
    CMD_HISTORY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [1:0]              batch_index;
    logic [9:0]              channel_index;
    logic [1:0]              tap_index;
    logic signed [DataW-1:0] data_value;
    logic                    last_token;
  } in_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] conv_out;
    logic [1:0]              out_batch;
    logic [9:0]              out_channel;
    logic                    out_last;
    logic                    saturated;
  } out_rsp_t;

  // request tags that ride along with the arithmetic
  typedef struct packed {
    logic [1:0] batch;
    logic [9:0] channel;
    logic       last;
  } meta_t;

endpackage

FILE: rtl/dcc_ram.sv
module dcc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dcc_hist.sv
module dcc_hist import dcc_pkg::*; #(
  parameter int unsigned Lanes = 3,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic [Lanes-1:0]        wlane_i,
  input  logic signed [DataW-1:0] wdata_i [Lanes],
  output logic signed [DataW-1:0] rdata_o [Lanes],
  output logic                    busy_o
);

  logic             busy_q, busy_d;
  logic [AddrW-1:0] clr_q, clr_d;

  logic             ram_we   [Lanes];
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata [Lanes];
  logic [DataW-1:0] ram_rdata [Lanes];

  logic                    fwd_hit_q;
  logic [Lanes-1:0]        fwd_lane_q;
  logic signed [DataW-1:0] fwd_data_q [Lanes];

  // zeroing sweep after reset, one row a cycle
  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      clr_d = clr_q + AddrW'(1);
      if (clr_q == AddrW'(Depth - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  assign ram_waddr = busy_q ? clr_q : waddr_i;

  // a write landing on the row read at the same edge is not seen by the RAM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q  <= 1'b0;
      fwd_lane_q <= '0;
    end else if (re_i) begin
      fwd_hit_q  <= we_i && !busy_q && (waddr_i == raddr_i);
      fwd_lane_q <= wlane_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      fwd_data_q <= wdata_i;
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    assign ram_we[l]    = busy_q || (we_i && wlane_i[l]);
    assign ram_wdata[l] = busy_q ? '0 : wdata_i[l];

    dcc_ram #(
      .Width (DataW),
      .Depth (Depth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[l]),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata[l]),
      .re_i    (re_i),
      .raddr_i (raddr_i),
      .rdata_o (ram_rdata[l])
    );

    assign rdata_o[l] = (fwd_hit_q && fwd_lane_q[l]) ? fwd_data_q[l]
                                                      : $signed(ram_rdata[l]);
  end

  assign busy_o = busy_q;

endmodule

FILE: rtl/dcc_mac.sv
module dcc_mac import dcc_pkg::*; #(
  parameter int unsigned MaxTaps = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DataW-1:0] a_i [MaxTaps],
  input  logic signed [DataW-1:0] w_i [MaxTaps],
  input  meta_t                   meta_i,
  output logic                    valid_o,
  output out_rsp_t                rsp_o
);

  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned SumW  = ProdW + $clog2(MaxTaps) + 1;

  logic                    p_valid_q;
  logic signed [ProdW-1:0] prod_q [MaxTaps];
  meta_t                   p_meta_q;

  logic                    o_valid_q;
  out_rsp_t                o_rsp_q, o_rsp_d;

  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en_i) begin
      p_valid_q <= valid_i;
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < MaxTaps; t++) begin
        prod_q[t] <= a_i[t] * w_i[t];
      end
      p_meta_q <= meta_i;
      o_rsp_q  <= o_rsp_d;
    end
  end

  // Q2.14 products: round half up, then clamp to 16 bits
  always_comb begin
    sum = '0;
    for (int t = 0; t < MaxTaps; t++) begin
      sum = sum + SumW'(prod_q[t]);
    end
    rnd = (sum + SumW'(8192)) >>> 14;
    o_rsp_d.out_batch   = p_meta_q.batch;
    o_rsp_d.out_channel = p_meta_q.channel;
    o_rsp_d.out_last    = p_meta_q.last;
    if (rnd > SumW'(32767)) begin
      o_rsp_d.conv_out  = 16'sh7fff;
      o_rsp_d.saturated = 1'b1;
    end else if (rnd < SumW'(-32768)) begin
      o_rsp_d.conv_out  = 16'sh8000;
      o_rsp_d.saturated = 1'b1;
    end else begin
      o_rsp_d.conv_out  = rnd[DataW-1:0];
      o_rsp_d.saturated = 1'b0;
    end
  end

  assign valid_o = o_valid_q;
  assign rsp_o   = o_rsp_q;

endmodule

FILE: rtl/depthwise_causal_conv_core.sv
// Depthwise causal convolution core: a per-channel FIR over a request stream. One
// request is taken every cycle unless the output stalls or the history clear runs;
// a sample request returns its result through the history/weight read, multiply
// and sum/round/saturate registers, while weight and history write requests return
// nothing. The history row read-modify-write does not limit the request rate, the
// next row read being forwarded from the write port when it hits the same entry.
// After reset the history memory is zeroed, one row per cycle, over MAX_BATCH*CHANNELS
// rows (4096 with default parameters) with in_ready_o low; taps_in_use can be written
// meanwhile. Weights are undefined until written. Write taps_in_use only while idle.
module depthwise_causal_conv_core import dcc_pkg::*; #(
  parameter int unsigned MAX_TAPS  = 4,
  parameter int unsigned CHANNELS  = 1024,
  parameter int unsigned MAX_BATCH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_rsp_t          out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned Lanes  = MAX_TAPS - 1;
  localparam int unsigned HDepth = MAX_BATCH * CHANNELS;
  localparam int unsigned HAddrW = (HDepth > 1) ? $clog2(HDepth) : 1;
  localparam int unsigned WAddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned KW     = $clog2(MAX_TAPS + 1);

  // ---------------- configuration
  logic [TapsW-1:0] taps_q, taps_d;
  logic             cfg_we;
  logic [KW-1:0]    klen, hs;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegTapsInUse);
  assign taps_d = cfg_we ? pwdata[TapsW-1:0] : taps_q;
  assign prdata = (paddr[2] == RegTapsInUse) ? {{(PdataW - TapsW){1'b0}}, taps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TapsReset;
    end else begin
      taps_q <= taps_d;
    end
  end

  always_comb begin
    if (taps_q < 3'd2) begin
      klen = KW'(2);
    end else if (int'(taps_q) > MAX_TAPS) begin
      klen = KW'(MAX_TAPS);
    end else begin
      klen = KW'(taps_q);
    end
    hs = klen - KW'(1);
  end

  // ---------------- request decode
  logic              en, in_fire, idx_ok, hist_busy;
  logic              is_sample, is_weight, is_history;
  logic [HAddrW-1:0] in_haddr;
  logic [WAddrW-1:0] in_waddr;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en && !hist_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  assign idx_ok     = (int'(in_req_i.batch_index) < MAX_BATCH) &&
                      (int'(in_req_i.channel_index) < CHANNELS);
  assign is_sample  = in_req_i.command == CMD_SAMPLE;
  assign is_weight  = in_req_i.command == CMD_WEIGHT;
  assign is_history = in_req_i.command == CMD_HISTORY;
  assign in_haddr   = HAddrW'(int'(in_req_i.batch_index) * CHANNELS +
                              int'(in_req_i.channel_index));
  assign in_waddr   = WAddrW'(in_req_i.channel_index);

  // ---------------- weight store, one RAM per tap
  logic [DataW-1:0]        w_raw [MAX_TAPS];
  logic signed [DataW-1:0] w_row [MAX_TAPS];

  for (genvar t = 0; t < MAX_TAPS; t++) begin : g_wlane
    logic w_we;
    assign w_we = in_fire && idx_ok && is_weight && (int'(in_req_i.tap_index) == t);

    dcc_ram #(
      .Width (DataW),
      .Depth (CHANNELS)
    ) u_wram (
      .clk_i   (clk_i),
      .we_i    (w_we),
      .waddr_i (in_waddr),
      .wdata_i (in_req_i.data_value),
      .re_i    (en),
      .raddr_i (in_waddr),
      .rdata_o (w_raw[t])
    );

    assign w_row[t] = $signed(w_raw[t]);
  end

  // ---------------- stage 1: row read returns, history write-back
  logic                    s1_valid_q;
  logic                    s1_sample_q;
  logic [HAddrW-1:0]       s1_haddr_q;
  logic [1:0]              s1_tap_q;
  logic signed [DataW-1:0] s1_data_q;
  meta_t                   s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_fire && idx_ok && (is_sample || is_history);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q       <= is_sample;
      s1_haddr_q        <= in_haddr;
      s1_tap_q          <= in_req_i.tap_index;
      s1_data_q         <= in_req_i.data_value;
      s1_meta_q.batch   <= in_req_i.batch_index;
      s1_meta_q.channel <= in_req_i.channel_index;
      s1_meta_q.last    <= in_req_i.last_token;
    end
  end

  logic signed [DataW-1:0] h_row  [Lanes];
  logic signed [DataW-1:0] h_ext  [MAX_TAPS];
  logic signed [DataW-1:0] h_new  [Lanes];
  logic signed [DataW-1:0] mac_a  [MAX_TAPS];
  logic signed [DataW-1:0] mac_w  [MAX_TAPS];
  logic [Lanes-1:0]        h_lane;
  logic                    h_we;

  always_comb begin
    for (int t = 0; t < Lanes; t++) begin
      h_ext[t] = h_row[t];
    end
    h_ext[MAX_TAPS-1] = '0;

    // operands: history oldest first, then the current sample at tap K-1;
    // weights past K-1 may never have been written, so they are dropped
    for (int t = 0; t < MAX_TAPS; t++) begin
      if (KW'(t) < hs) begin
        mac_a[t] = h_ext[t];
        mac_w[t] = w_row[t];
      end else if (KW'(t) == hs) begin
        mac_a[t] = s1_data_q;
        mac_w[t] = w_row[t];
      end else begin
        mac_a[t] = '0;
        mac_w[t] = '0;
      end
    end

    h_we   = 1'b0;
    h_lane = '0;
    for (int t = 0; t < Lanes; t++) begin
      h_new[t] = s1_data_q;
    end
    if (s1_sample_q) begin
      // shift used slots down and append; slots past K-2 keep their value
      h_we   = s1_valid_q && en;
      h_lane = '1;
      for (int t = 0; t < Lanes; t++) begin
        if (KW'(t + 1) < hs) begin
          h_new[t] = h_ext[t + 1];
        end else if (KW'(t + 1) == hs) begin
          h_new[t] = s1_data_q;
        end else begin
          h_new[t] = h_row[t];
        end
      end
    end else if (KW'(s1_tap_q) < hs) begin
      h_we = s1_valid_q && en;
      for (int t = 0; t < Lanes; t++) begin
        h_lane[t] = int'(s1_tap_q) == t;
      end
    end
  end

  dcc_hist #(
    .Lanes (Lanes),
    .Depth (HDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (en),
    .raddr_i (in_haddr),
    .we_i    (h_we),
    .waddr_i (s1_haddr_q),
    .wlane_i (h_lane),
    .wdata_i (h_new),
    .rdata_o (h_row),
    .busy_o  (hist_busy)
  );

  // ---------------- multiply, sum, round, output register
  dcc_mac #(
    .MaxTaps (MAX_TAPS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q && s1_sample_q),
    .a_i     (mac_a),
    .w_i     (mac_w),
    .meta_i  (s1_meta_q),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

endmodule

FILE: rtl/dcc_checker.sv
module dcc_checker import dcc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input out_rsp_t          out_rsp_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [PaddrW-1:0] paddr,
  input logic [PdataW-1:0] pwdata,
  input logic [PdataW-1:0] prdata,
  input logic              pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // clipping flag only with a rail value
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.saturated |->
      out_rsp_o.conv_out == 16'sh7fff || out_rsp_o.conv_out == 16'sh8000)
    else $error("saturated without rail value");

  // history clear runs right after reset, no requests taken
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("request taken before history clear");

  // register readback follows a write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && pready && paddr[2] == RegTapsInUse) &&
      paddr[2] == RegTapsInUse |-> prdata[TapsW-1:0] == $past(pwdata[TapsW-1:0]))
    else $error("taps_in_use readback mismatch");

endmodule

bind depthwise_causal_conv_core dcc_checker u_dcc_checker (.*);
